// ===== sv/ect_pkg.sv =====
// ect_pkg: shared types, constants and constant tables of the epoch to calendar converter
// no dependencies; used by the microcode rom, sequencer, datapath, top level and checker
`default_nettype none

package ect_pkg;

  // field widths
  localparam int EPOCH_W = 33;
  localparam int ZONE_W  = 5;
  localparam int SEC_W   = 6;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 8;

  // microprogram counter
  localparam int UPC_W = 5;

  // calendar constants
  localparam logic [ZONE_W-1:0] ZONE_RESET      = 5'd8;
  localparam logic [16:0]       SECS_PER_HOUR   = 17'd3600;
  localparam logic [13:0]       YEAR_HOURS      = 14'd8760;
  localparam logic [13:0]       LEAP_YEAR_HOURS = 14'd8784;
  localparam logic [8:0]        LEAP_DAY        = 9'd60;
  localparam logic [DAY_W-1:0]  FEB_LAST_LEAP   = 5'd29;
  localparam logic [YEAR_W-1:0] BASE_YEAR       = 8'd70;
  localparam logic [MON_W-1:0]  MON_JAN         = 4'd0;
  localparam logic [MON_W-1:0]  MON_FEB         = 4'd1;
  localparam logic [MON_W-1:0]  MON_DEC         = 4'd11;

  // microcode step addresses that are jump targets
  localparam logic [UPC_W-1:0] STEP_DONE = 5'd20;

  // datapath operations
  typedef enum logic [3:0] {
    OP_ZONE,   // add zone offset, clamp at zero
    OP_MULR,   // prod = (acc >> pre) * reciprocal
    OP_QUOT,   // q = prod >> post
    OP_MULD,   // prod = q * divisor
    OP_REM,    // remainder and quotient to their destinations
    OP_YEAR,   // one step of the year walk
    OP_LEAP,   // leap day fix-up
    OP_MONTH,  // one step of the month walk
    OP_DONE    // no datapath work
  } op_t;

  // divisor constant sets
  typedef enum logic [1:0] {
    KS_SIXTY,
    KS_FOURYEAR,
    KS_DAY
  } ksel_t;

  // where a division's results go
  typedef enum logic [1:0] {
    DST_SEC,
    DST_MIN,
    DST_YEAR,
    DST_HOUR
  } dst_t;

  // sequencing of the next step
  typedef enum logic [1:0] {
    JC_NEXT,    // pc + 1
    JC_LOOP,    // repeat this step until loop exit
    JC_BRANCH,  // jump to target when branch is taken
    JC_END      // publish result and go idle
  } jc_t;

  typedef struct packed {
    op_t              op;
    ksel_t            ksel;
    dst_t             dst;
    jc_t              jc;
    logic [UPC_W-1:0] target;
  } uword_t;

  // sequencer to datapath
  typedef struct packed {
    logic  load;
    logic  exec;
    logic  publish;
    op_t   op;
    ksel_t ksel;
    dst_t  dst;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic loop_exit;
    logic branch_taken;
  } stat_t;

  // constant divider: q = ((x >> pre) * recip) >> post, r = x - q * divisor
  typedef struct packed {
    logic [1:0]  pre;
    logic [31:0] recip;
    logic [5:0]  post;
    logic [15:0] divisor;
  } divk_t;

  function automatic divk_t divk(ksel_t k);
    divk_t d;
    case (k)
      KS_SIXTY: begin
        d = '{pre: 2'd2, recip: 32'd2290649225, post: 6'd35, divisor: 16'd60};
      end
      KS_FOURYEAR: begin
        d = '{pre: 2'd3, recip: 32'd979915, post: 6'd32, divisor: 16'd35064};
      end
      KS_DAY: begin
        d = '{pre: 2'd3, recip: 32'd21846, post: 6'd16, divisor: 16'd24};
      end
      default: begin
        d = '{pre: 2'd2, recip: 32'd2290649225, post: 6'd35, divisor: 16'd60};
      end
    endcase
    return d;
  endfunction

  // days in month, february as a common year
  function automatic logic [DAY_W-1:0] month_len(logic [MON_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1:                    n = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/epoch_to_calendar_date.sv =====
// epoch_to_calendar_date: top level of the epoch seconds to calendar date converter
// depends on ect_pkg, ect_seq (with ect_urom) and ect_dpath
//
// usage
//   input channel: in_valid / in_stall carry one 33-bit signed epoch count a transaction;
//   a transaction is taken at a clock edge with in_valid high and in_stall low
//   output channel: out_valid / out_stall carry second, minute, hour, day, month and
//   years since 1900; the result register holds still while out_stall is high
//   config: cfg_wr_en writes cfg_wr_data to the zone offset (signed hours) at any edge;
//   change it only while no transaction is in flight
// timing
//   a microcoded program runs one step per cycle over a shared multiplier; constant
//   divisions use reciprocal multiply, back-multiply and subtract (4 steps each),
//   then the year walk (1 to 4 steps) and month walk (up to 12, none on a leap day) run
//   the next input is taken in the cycle after the result register loads, so only
//   one item is converted at a time; the result register frees the sequencer
//   while a result waits
//   if out_stall holds a previous result, the program waits at its last step
// reset
//   synchronous active-low rst_n: sequencer idle, no result valid, zone offset 8
`default_nettype none

module epoch_to_calendar_date
  import ect_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // config port
  input  wire logic               cfg_wr_en,
  input  wire logic [ZONE_W-1:0]  cfg_wr_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [EPOCH_W-1:0] in_epoch_seconds,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [SEC_W-1:0]        out_second_of_minute,
  output logic [MIN_W-1:0]        out_minute_of_hour,
  output logic [HOUR_W-1:0]       out_hour_of_day,
  output logic [DAY_W-1:0]        out_day_of_month,
  output logic [MON_W-1:0]        out_month_index,
  output logic [YEAR_W-1:0]       out_years_since_1900
);

  logic [ZONE_W-1:0] zone_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  ctl_t              ctl;
  stat_t             stat;

  // zone offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= ZONE_RESET;
    end else if (cfg_wr_en) begin
      zone_r <= cfg_wr_data;
    end
  end

  // result slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.publish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  ect_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl)
  );

  ect_dpath u_dpath (
    .clk      (clk),
    .ctl      (ctl),
    .epoch    (in_epoch_seconds),
    .zone     (zone_r),
    .stat     (stat),
    .out_sec  (out_second_of_minute),
    .out_min  (out_minute_of_hour),
    .out_hour (out_hour_of_day),
    .out_day  (out_day_of_month),
    .out_mon  (out_month_index),
    .out_year (out_years_since_1900)
  );

endmodule

`default_nettype wire

// ===== sv/ect_urom.sv =====
// ect_urom: microcode rom holding the conversion program, one control word per step
// depends on ect_pkg for the control word layout
`default_nettype none

module ect_urom
  import ect_pkg::*;
(
  input  wire logic [UPC_W-1:0] pc,
  output uword_t                uword
);

  always_comb begin
    case (pc)
      // zone offset
      5'd0:  uword = '{OP_ZONE,  KS_SIXTY,    DST_SEC,  JC_NEXT,   '0};
      // seconds
      5'd1:  uword = '{OP_MULR,  KS_SIXTY,    DST_SEC,  JC_NEXT,   '0};
      5'd2:  uword = '{OP_QUOT,  KS_SIXTY,    DST_SEC,  JC_NEXT,   '0};
      5'd3:  uword = '{OP_MULD,  KS_SIXTY,    DST_SEC,  JC_NEXT,   '0};
      5'd4:  uword = '{OP_REM,   KS_SIXTY,    DST_SEC,  JC_NEXT,   '0};
      // minutes
      5'd5:  uword = '{OP_MULR,  KS_SIXTY,    DST_MIN,  JC_NEXT,   '0};
      5'd6:  uword = '{OP_QUOT,  KS_SIXTY,    DST_MIN,  JC_NEXT,   '0};
      5'd7:  uword = '{OP_MULD,  KS_SIXTY,    DST_MIN,  JC_NEXT,   '0};
      5'd8:  uword = '{OP_REM,   KS_SIXTY,    DST_MIN,  JC_NEXT,   '0};
      // four-year blocks
      5'd9:  uword = '{OP_MULR,  KS_FOURYEAR, DST_YEAR, JC_NEXT,   '0};
      5'd10: uword = '{OP_QUOT,  KS_FOURYEAR, DST_YEAR, JC_NEXT,   '0};
      5'd11: uword = '{OP_MULD,  KS_FOURYEAR, DST_YEAR, JC_NEXT,   '0};
      5'd12: uword = '{OP_REM,   KS_FOURYEAR, DST_YEAR, JC_NEXT,   '0};
      // year walk
      5'd13: uword = '{OP_YEAR,  KS_SIXTY,    DST_SEC,  JC_LOOP,   '0};
      // hour of day and day of year
      5'd14: uword = '{OP_MULR,  KS_DAY,      DST_HOUR, JC_NEXT,   '0};
      5'd15: uword = '{OP_QUOT,  KS_DAY,      DST_HOUR, JC_NEXT,   '0};
      5'd16: uword = '{OP_MULD,  KS_DAY,      DST_HOUR, JC_NEXT,   '0};
      5'd17: uword = '{OP_REM,   KS_DAY,      DST_HOUR, JC_NEXT,   '0};
      // leap day goes straight to the end
      5'd18: uword = '{OP_LEAP,  KS_SIXTY,    DST_SEC,  JC_BRANCH, STEP_DONE};
      // month walk
      5'd19: uword = '{OP_MONTH, KS_SIXTY,    DST_SEC,  JC_LOOP,   '0};
      5'd20: uword = '{OP_DONE,  KS_SIXTY,    DST_SEC,  JC_END,    '0};
      default: uword = '{OP_DONE, KS_SIXTY,   DST_SEC,  JC_END,    '0};
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/ect_seq.sv =====
// ect_seq: microprogram sequencer with step counter, conditional jumps and input handshake
// depends on ect_pkg and ect_urom
`default_nettype none

module ect_seq
  import ect_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output ctl_t       ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [UPC_W-1:0] pc_r, pc_nxt;
  uword_t           uw;
  logic             accept;
  logic             run;

  ect_urom u_urom (
    .pc    (pc_r),
    .uword (uw)
  );

  assign run      = (state_r == S_RUN);
  assign in_stall = !(state_r == S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl.load    = accept;
    ctl.exec    = run;
    ctl.publish = run && (uw.jc == JC_END) && out_free;
    ctl.op      = uw.op;
    ctl.ksel    = uw.ksel;
    ctl.dst     = uw.dst;
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
          pc_nxt    = '0;
        end
      end
      S_RUN: begin
        case (uw.jc)
          JC_NEXT:   pc_nxt = pc_r + 1'b1;
          JC_LOOP:   pc_nxt = stat.loop_exit ? pc_r + 1'b1 : pc_r;
          JC_BRANCH: pc_nxt = stat.branch_taken ? uw.target : pc_r + 1'b1;
          JC_END: begin
            if (out_free) begin
              state_nxt = S_IDLE;
            end
          end
          default:   pc_nxt = pc_r;
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ect_dpath.sv =====
// ect_dpath: working registers, shared multiplier and result registers of the converter
// depends on ect_pkg for control and status structs and constant tables
`default_nettype none

module ect_dpath
  import ect_pkg::*;
(
  input  wire logic               clk,
  input  wire ctl_t               ctl,
  input  wire logic [EPOCH_W-1:0] epoch,
  input  wire logic [ZONE_W-1:0]  zone,
  output stat_t                   stat,
  output logic [SEC_W-1:0]        out_sec,
  output logic [MIN_W-1:0]        out_min,
  output logic [HOUR_W-1:0]       out_hour,
  output logic [DAY_W-1:0]        out_day,
  output logic [MON_W-1:0]        out_mon,
  output logic [YEAR_W-1:0]       out_year
);

  logic [EPOCH_W-1:0] acc_r, acc_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [63:0]        prod_r, prod_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [MON_W-1:0]   mon_r, mon_nxt;
  logic [YEAR_W-1:0]  year_r, year_nxt;

  divk_t              k;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [16:0]        zone_prod;
  logic [33:0]        zone_sum;
  logic [EPOCH_W-1:0] rem;
  logic               leap;
  logic [13:0]        year_len;
  logic               year_exit;
  logic [DAY_W-1:0]   mon_len;
  logic               mon_exit;
  logic               leap_day;

  assign k = divk(ctl.ksel);

  // one shared multiplier: reciprocal pass or back-multiply pass
  assign mul_a = (ctl.op == OP_MULD) ? q_r : 32'(acc_r >> k.pre);
  assign mul_b = (ctl.op == OP_MULD) ? {16'd0, k.divisor} : k.recip;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign zone_prod = $signed({{12{zone[ZONE_W-1]}}, zone}) * $signed(SECS_PER_HOUR);
  assign zone_sum  = {acc_r[EPOCH_W-1], acc_r} + {{17{zone_prod[16]}}, zone_prod};

  assign rem = acc_r - prod_r[EPOCH_W-1:0];

  assign leap      = (year_r[1:0] == 2'b00);
  assign year_len  = leap ? LEAP_YEAR_HOURS : YEAR_HOURS;
  assign year_exit = acc_r < EPOCH_W'(year_len);
  assign mon_len   = month_len(mon_r);
  assign mon_exit  = (mon_r == MON_DEC) || (EPOCH_W'(mon_len) >= acc_r);
  assign leap_day  = leap && (acc_r == EPOCH_W'(LEAP_DAY));

  always_comb begin
    stat.loop_exit    = 1'b1;
    stat.branch_taken = 1'b0;
    case (ctl.op)
      OP_YEAR:  stat.loop_exit = year_exit;
      OP_MONTH: stat.loop_exit = mon_exit;
      OP_LEAP:  stat.branch_taken = leap_day;
      default:  stat.loop_exit = 1'b1;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    prod_nxt = prod_r;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    if (ctl.load) begin
      acc_nxt = epoch;
    end else if (ctl.exec) begin
      case (ctl.op)
        OP_ZONE: begin
          acc_nxt = zone_sum[33] ? '0 : zone_sum[EPOCH_W-1:0];
        end
        OP_MULR, OP_MULD: begin
          prod_nxt = mul_p;
        end
        OP_QUOT: begin
          q_nxt = 32'(prod_r >> k.post);
        end
        OP_REM: begin
          case (ctl.dst)
            DST_SEC: begin
              sec_nxt = rem[SEC_W-1:0];
              acc_nxt = EPOCH_W'(q_r);
            end
            DST_MIN: begin
              min_nxt = rem[MIN_W-1:0];
              acc_nxt = EPOCH_W'(q_r);
            end
            DST_YEAR: begin
              year_nxt = {q_r[5:0], 2'b00} + BASE_YEAR;
              acc_nxt  = rem;
            end
            DST_HOUR: begin
              hour_nxt = rem[HOUR_W-1:0];
              acc_nxt  = EPOCH_W'(q_r) + 1'b1;
            end
            default: begin
              acc_nxt = rem;
            end
          endcase
        end
        OP_YEAR: begin
          if (!year_exit) begin
            acc_nxt  = acc_r - EPOCH_W'(year_len);
            year_nxt = year_r + 1'b1;
          end
        end
        OP_LEAP: begin
          if (leap_day) begin
            mon_nxt = MON_FEB;
            acc_nxt = EPOCH_W'(FEB_LAST_LEAP);
          end else begin
            mon_nxt = MON_JAN;
            if (leap && (acc_r > EPOCH_W'(LEAP_DAY))) begin
              acc_nxt = acc_r - 1'b1;
            end
          end
        end
        OP_MONTH: begin
          if (!mon_exit) begin
            acc_nxt = acc_r - EPOCH_W'(mon_len);
            mon_nxt = mon_r + 1'b1;
          end
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    prod_r <= prod_nxt;
    sec_r  <= sec_nxt;
    min_r  <= min_nxt;
    hour_r <= hour_nxt;
    mon_r  <= mon_nxt;
    year_r <= year_nxt;
  end

  // result register, loaded when the program finishes and the output is free
  always_ff @(posedge clk) begin
    if (ctl.publish) begin
      out_sec  <= sec_r;
      out_min  <= min_r;
      out_hour <= hour_r;
      out_day  <= acc_r[DAY_W-1:0];
      out_mon  <= mon_r;
      out_year <= year_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ect_checker.sv =====
// ect_checker: port-level assertions for epoch_to_calendar_date, attached by bind
// depends on ect_pkg for field widths
`default_nettype none

module ect_checker
  import ect_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               cfg_wr_en,
  input wire logic [ZONE_W-1:0]  cfg_wr_data,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [EPOCH_W-1:0] in_epoch_seconds,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [SEC_W-1:0]   out_second_of_minute,
  input wire logic [MIN_W-1:0]   out_minute_of_hour,
  input wire logic [HOUR_W-1:0]  out_hour_of_day,
  input wire logic [DAY_W-1:0]   out_day_of_month,
  input wire logic [MON_W-1:0]   out_month_index,
  input wire logic [YEAR_W-1:0]  out_years_since_1900
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_second_of_minute)
      && $stable(out_minute_of_hour) && $stable(out_hour_of_day)
      && $stable(out_day_of_month) && $stable(out_month_index)
      && $stable(out_years_since_1900))
    else $error("stalled result changed");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while conversion in flight");

  // going idle means a result was just loaded into a free output slot
  a_idle_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> out_valid && $past(!out_valid || !out_stall))
    else $error("sequencer finished without a result");

  // every result is a real calendar time
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second_of_minute < 6'd60 && out_minute_of_hour < 6'd60
      && out_hour_of_day < 5'd24 && out_day_of_month != 5'd0
      && out_month_index <= MON_DEC && out_years_since_1900 >= BASE_YEAR
      && (out_month_index != MON_FEB || out_day_of_month <= FEB_LAST_LEAP))
    else $error("result field out of range");

endmodule

bind epoch_to_calendar_date ect_checker u_ect_checker (.*);

`default_nettype wire
